FILE: rtl/bdte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdte_pkg: shared types, codes and calendar tables
// Command and status bundles between the controller and the datapath,
// divider operation codes and the Gregorian month tables.
// ----------------------------------------------------------------------------
package bdte_pkg;

    // divider operation codes, in issue order
    typedef logic [2:0] t_op;
    localparam t_op OP_SEC  = 3'd0;
    localparam t_op OP_MIN  = 3'd1;
    localparam t_op OP_HOUR = 3'd2;
    localparam t_op OP_MON  = 3'd3;
    localparam t_op OP_Y400 = 3'd4;
    localparam t_op OP_P100 = 3'd5;
    localparam t_op OP_P400 = 3'd6;
    localparam t_op OP_WDAY = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_apply;
        t_op  op;
        logic walk;
        logic yday;
        logic days;
        logic mul;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic walk_done;
        logic range_err;
    } t_stat;

    // leap test on (years since 1900 + 1900) mod 400
    function automatic logic f_leap(input logic [8:0] m400);
        return (m400[1:0] == 2'b00) && (m400 != 9'd100) &&
               (m400 != 9'd200) && (m400 != 9'd300);
    endfunction

    // length of a zero-based month
    function automatic logic [4:0] f_days_in(input logic [3:0] mon, input logic leap);
        logic [4:0] d;
        case (mon)
            4'd1:                          d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:       d = 5'd30;
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7,
            4'd9, 4'd11:                   d = 5'd31;
            default:                       d = 5'd31;
        endcase
        return d;
    endfunction

    // days in a common year before the first of a month
    function automatic logic [8:0] f_days_before(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bdte_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdte_div: shared floor divider
// Divides by one of the small constant divisors through a reciprocal
// multiply, an estimate of the remainder and one correction step. The signed
// dividend is biased by divisor * 2^22 so the unsigned quotient is
// floor + 2^22 and the remainder is the non-negative floor remainder.
// Busy while the multiply, estimate and correction stages run.
// ----------------------------------------------------------------------------
module bdte_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dividend,
    input  logic        [8:0]  i_divisor,
    output logic               o_busy,
    output logic signed [31:0] o_quot,
    output logic        [8:0]  o_rem
);
    localparam int BIAS_SH = 22;

    // stage codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EST  = 2'd2;
    localparam logic [1:0] ST_FIX  = 2'd3;

    logic [1:0]  r_stage;
    logic [30:0] r_num;
    logic [30:0] r_recip;
    logic [8:0]  r_div;
    logic [30:0] r_qest;
    logic [9:0]  r_rest;
    logic [30:0] r_quot;
    logic [8:0]  r_rem;

    logic [30:0] biased;
    logic [30:0] recip;
    logic [61:0] prod;
    logic [9:0]  qd_low;
    logic        fix;

    // floor(2^31 / divisor); the estimate is low by at most one
    always_comb begin
        case (i_divisor)
            9'd7:    recip = 31'd306783378;
            9'd12:   recip = 31'd178956970;
            9'd24:   recip = 31'd89478485;
            9'd60:   recip = 31'd35791394;
            9'd100:  recip = 31'd21474836;
            9'd400:  recip = 31'd5368709;
            default: recip = 31'h7FFFFFFF;
        endcase
    end

    assign biased = i_dividend[30:0] + {i_divisor, {BIAS_SH{1'b0}}};
    assign prod   = r_num * r_recip;
    assign qd_low = 10'(r_qest[9:0] * {1'b0, r_div});
    assign fix    = r_rest >= {1'b0, r_div};

    // stage sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
        end else if (i_start) begin
            r_stage <= ST_MUL;
        end else begin
            case (r_stage)
                ST_MUL:  r_stage <= ST_EST;
                ST_EST:  r_stage <= ST_FIX;
                ST_FIX:  r_stage <= ST_IDLE;
                default: r_stage <= ST_IDLE;
            endcase
        end
    end

    // estimate, remainder and correction
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num   <= biased;
            r_div   <= i_divisor;
            r_recip <= recip;
        end
        case (r_stage)
            ST_MUL: r_qest <= prod[61:31];
            // true remainder is below twice the divisor, ten bits suffice
            ST_EST: r_rest <= r_num[9:0] - qd_low;
            ST_FIX: begin
                r_quot <= r_qest + {30'd0, fix};
                r_rem  <= fix ? 9'(r_rest - {1'b0, r_div}) : r_rest[8:0];
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_stage != ST_IDLE);
    assign o_quot = $signed({1'b0, r_quot} - (32'd1 << BIAS_SH));
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: rtl/bdte_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdte_datapath: field registers, divider, month walk and epoch arithmetic
// Executes one command per cycle from the controller and reports status.
// ----------------------------------------------------------------------------
module bdte_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bdte_pkg::t_cmd       i_cmd,
    output bdte_pkg::t_stat      o_stat,
    input  logic signed [15:0]   i_second_in,
    input  logic signed [15:0]   i_minute_in,
    input  logic signed [15:0]   i_hour_in,
    input  logic signed [15:0]   i_day_in,
    input  logic signed [15:0]   i_month_in,
    input  logic signed [15:0]   i_year_in,
    output logic                 o_valid,
    output logic signed [39:0]   o_epoch_seconds,
    output logic        [5:0]    o_second_out,
    output logic        [5:0]    o_minute_out,
    output logic        [4:0]    o_hour_out,
    output logic        [4:0]    o_day_out,
    output logic        [3:0]    o_month_out,
    output logic signed [16:0]   o_year_out,
    output logic        [8:0]    o_year_day,
    output logic        [2:0]    o_week_day,
    output logic                 o_range_error
);
    import bdte_pkg::*;

    localparam logic signed [16:0] C_YEAR_LIMIT   = 17'sd10000;
    localparam logic signed [16:0] C_YEAR_BASE    = 17'sd1900;
    localparam logic signed [16:0] C_EPOCH_REL    = 17'sd70;
    localparam logic signed [23:0] C_DAYS_YEAR    = 24'sd365;
    localparam logic signed [23:0] C_LEAPS_EPOCH  = 24'sd477;
    localparam logic signed [39:0] C_SECS_DAY     = 40'sd86400;

    // working registers
    logic signed [15:0] r_sec_in, r_mon_in;
    logic signed [16:0] r_min_w, r_hour_w, r_mday, r_year, r_lb;
    logic        [5:0]  r_sec, r_min;
    logic        [4:0]  r_hour;
    logic        [3:0]  r_mon;
    logic        [8:0]  r_y400, r_yday;
    logic               r_err;
    logic        [2:0]  r_wday;
    logic        [16:0] r_tod;
    logic signed [23:0] r_days;
    logic signed [39:0] r_prod;

    // divider hookup
    logic signed [31:0] div_a, div_q;
    logic        [8:0]  div_d, div_rem;
    logic               div_busy;
    logic signed [16:0] q17;

    logic signed [16:0] year_b, year_p;

    // month walk
    logic               back, over, walk_done, wrap_back, leap_cur, leap_prev;
    logic        [3:0]  mon_prev;
    logic        [8:0]  y400_inc, y400_dec;
    logic        [4:0]  dim_cur, dim_prev;

    // day count and time of day
    logic signed [16:0] yrel;
    logic signed [23:0] yrel24, lb24, yday24, days_calc;
    logic signed [39:0] days40, tod40;
    logic        [8:0]  yday_calc;
    logic        [16:0] tod_calc;
    logic               err_calc;

    bdte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_d),
        .o_busy     (div_busy),
        .o_quot     (div_q),
        .o_rem      (div_rem)
    );

    assign q17    = div_q[16:0];
    assign year_b = r_year + C_YEAR_BASE;
    assign year_p = r_year + C_YEAR_BASE - 17'sd1;

    // divider operand select
    always_comb begin
        div_a = '0;
        div_d = 9'd1;
        case (i_cmd.op)
            OP_SEC: begin
                div_a = {{16{r_sec_in[15]}}, r_sec_in};
                div_d = 9'd60;
            end
            OP_MIN: begin
                div_a = {{15{r_min_w[16]}}, r_min_w};
                div_d = 9'd60;
            end
            OP_HOUR: begin
                div_a = {{15{r_hour_w[16]}}, r_hour_w};
                div_d = 9'd24;
            end
            OP_MON: begin
                div_a = {{16{r_mon_in[15]}}, r_mon_in};
                div_d = 9'd12;
            end
            OP_Y400: begin
                div_a = {{15{year_b[16]}}, year_b};
                div_d = 9'd400;
            end
            OP_P100: begin
                div_a = {{15{year_p[16]}}, year_p};
                div_d = 9'd100;
            end
            OP_P400: begin
                div_a = {{15{year_p[16]}}, year_p};
                div_d = 9'd400;
            end
            OP_WDAY: begin
                div_a = {{8{r_days[23]}}, r_days} + 32'sd4;
                div_d = 9'd7;
            end
            default: begin
                div_a = '0;
                div_d = 9'd1;
            end
        endcase
    end

    // one month step per cycle, backward while the day is not positive
    assign back      = r_mday[16] || (r_mday == '0);
    assign wrap_back = (r_mon == 4'd0);
    assign mon_prev  = wrap_back ? 4'd11 : r_mon - 4'd1;
    assign y400_inc  = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
    assign y400_dec  = (r_y400 == 9'd0) ? 9'd399 : r_y400 - 9'd1;
    assign leap_cur  = f_leap(r_y400);
    assign leap_prev = f_leap(wrap_back ? y400_dec : r_y400);
    assign dim_cur   = f_days_in(r_mon, leap_cur);
    assign dim_prev  = f_days_in(mon_prev, leap_prev);
    assign over      = !back && (r_mday > $signed({12'd0, dim_cur}));
    assign walk_done = !back && !over;

    // day of year and range check
    assign yday_calc = r_mday[8:0] - 9'd1 + f_days_before(r_mon) +
                       {8'd0, (r_mon > 4'd1) && leap_cur};
    assign err_calc  = (r_year > C_YEAR_LIMIT) || (r_year < -C_YEAR_LIMIT);

    // days since the epoch
    assign yrel      = r_year - C_EPOCH_REL;
    assign yrel24    = {{7{yrel[16]}}, yrel};
    assign lb24      = {{7{r_lb[16]}}, r_lb};
    assign yday24    = {15'd0, r_yday};
    assign days_calc = yrel24 * C_DAYS_YEAR + lb24 - C_LEAPS_EPOCH + yday24;
    assign tod_calc  = 17'(r_hour) * 17'd3600 + 17'(r_min) * 17'd60 + 17'(r_sec);
    assign days40    = {{16{r_days[23]}}, r_days};
    assign tod40     = {23'd0, r_tod};

    // working register updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sec_in <= i_second_in;
            r_min_w  <= {i_minute_in[15], i_minute_in};
            r_hour_w <= {i_hour_in[15], i_hour_in};
            r_mday   <= {i_day_in[15], i_day_in};
            r_mon_in <= i_month_in;
            r_year   <= {i_year_in[15], i_year_in};
        end
        if (i_cmd.div_apply) begin
            case (i_cmd.op)
                OP_SEC: begin
                    r_sec   <= div_rem[5:0];
                    r_min_w <= r_min_w + q17;
                end
                OP_MIN: begin
                    r_min    <= div_rem[5:0];
                    r_hour_w <= r_hour_w + q17;
                end
                OP_HOUR: begin
                    r_hour <= div_rem[4:0];
                    r_mday <= r_mday + q17;
                end
                OP_MON: begin
                    r_mon  <= div_rem[3:0];
                    r_year <= r_year + q17;
                end
                OP_Y400: r_y400 <= div_rem;
                OP_P100: r_lb   <= (year_p >>> 2) - q17;
                OP_P400: r_lb   <= r_lb + q17;
                OP_WDAY: r_wday <= div_rem[2:0];
                default: r_wday <= r_wday;
            endcase
        end
        if (i_cmd.walk && !walk_done) begin
            if (back) begin
                r_mday <= r_mday + $signed({12'd0, dim_prev});
                r_mon  <= mon_prev;
                if (wrap_back) begin
                    r_year <= r_year - 17'sd1;
                    r_y400 <= y400_dec;
                end
            end else begin
                r_mday <= r_mday - $signed({12'd0, dim_cur});
                if (r_mon == 4'd11) begin
                    r_mon  <= 4'd0;
                    r_year <= r_year + 17'sd1;
                    r_y400 <= y400_inc;
                end else begin
                    r_mon <= r_mon + 4'd1;
                end
            end
        end
        if (i_cmd.yday) begin
            r_yday <= yday_calc;
            r_err  <= err_calc;
        end
        if (i_cmd.days) begin
            r_days <= days_calc;
            r_tod  <= tod_calc;
        end
        if (i_cmd.mul) begin
            r_prod <= days40 * C_SECS_DAY;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_epoch_seconds <= r_err ? -40'sd1 : r_prod + tod40;
            o_week_day      <= r_err ? 3'd0 : r_wday;
            o_second_out    <= r_sec;
            o_minute_out    <= r_min;
            o_hour_out      <= r_hour;
            o_day_out       <= r_mday[4:0];
            o_month_out     <= r_mon;
            o_year_out      <= r_year;
            o_year_day      <= r_yday;
            o_range_error   <= r_err;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_load;
        end
    end

    assign o_stat.div_busy  = div_busy;
    assign o_stat.walk_done = walk_done;
    assign o_stat.range_err = r_err;

endmodule
`default_nettype wire

FILE: rtl/bdte_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdte_ctrl: sequencing state machine
// Steps one request through the field carries, the month walk, the leap
// count, the weekday and the seconds product.
// ----------------------------------------------------------------------------
module bdte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bdte_pkg::t_stat i_stat,
    output logic            o_busy,
    output bdte_pkg::t_cmd  o_cmd
);
    import bdte_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_GO   = 4'd1;
    localparam logic [3:0] S_DIV_WAIT = 4'd2;
    localparam logic [3:0] S_WALK     = 4'd3;
    localparam logic [3:0] S_YDAY     = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_DAYS     = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0] r_state, n_state;
    t_op        r_op, n_op;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_SEC;
                    n_state    = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.div_apply = 1'b1;
                    case (r_op)
                        OP_SEC: begin
                            n_op    = OP_MIN;
                            n_state = S_DIV_GO;
                        end
                        OP_MIN: begin
                            n_op    = OP_HOUR;
                            n_state = S_DIV_GO;
                        end
                        OP_HOUR: begin
                            n_op    = OP_MON;
                            n_state = S_DIV_GO;
                        end
                        OP_MON: begin
                            n_op    = OP_Y400;
                            n_state = S_DIV_GO;
                        end
                        OP_Y400: n_state = S_WALK;
                        OP_P100: begin
                            n_op    = OP_P400;
                            n_state = S_DIV_GO;
                        end
                        OP_P400: n_state = S_DAYS;
                        OP_WDAY: n_state = S_MUL;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_YDAY;
                end
            end
            S_YDAY: begin
                o_cmd.yday = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                // out-of-range year skips the day count
                if (i_stat.range_err) begin
                    n_state = S_OUT;
                end else begin
                    n_op    = OP_P100;
                    n_state = S_DIV_GO;
                end
            end
            S_DAYS: begin
                o_cmd.days = 1'b1;
                n_op       = OP_WDAY;
                n_state    = S_DIV_GO;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_SEC;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/broken_down_time_to_epoch_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_unit: calendar normalizer and Unix time converter
// Normalizes an out-of-range broken-down time (UTC, Gregorian) and returns
// the normalized fields, day of year, day of week and seconds since 1970.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; the six
//   16-bit signed fields are sampled at that edge. busy stays high until the
//   result has been loaded.
//   The result appears on the o_ ports with o_valid high for one cycle. The
//   receiver has no stall; it must take the result in that cycle.
//   A request passes through eight floor divisions on one shared
//   reciprocal-multiply divider and the month walk, which steps the day carry
//   one month per cycle for as many months as it spans. An out-of-range year
//   skips three divisions, the day count and the product.
//   busy drops in the cycle the strobe is shown, so the next request may be
//   taken then; requests are handled one at a time.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and clears
//   the strobe; no memory needs clearing.
// ----------------------------------------------------------------------------
module broken_down_time_to_epoch_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  i_second_in,
    input  logic signed [15:0]  i_minute_in,
    input  logic signed [15:0]  i_hour_in,
    input  logic signed [15:0]  i_day_in,
    input  logic signed [15:0]  i_month_in,
    input  logic signed [15:0]  i_year_in,
    output logic                o_valid,
    output logic signed [39:0]  o_epoch_seconds,
    output logic        [5:0]   o_second_out,
    output logic        [5:0]   o_minute_out,
    output logic        [4:0]   o_hour_out,
    output logic        [4:0]   o_day_out,
    output logic        [3:0]   o_month_out,
    output logic signed [16:0]  o_year_out,
    output logic        [8:0]   o_year_day,
    output logic        [2:0]   o_week_day,
    output logic                o_range_error
);
    import bdte_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    bdte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // datapath
    bdte_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_second_in     (i_second_in),
        .i_minute_in     (i_minute_in),
        .i_hour_in       (i_hour_in),
        .i_day_in        (i_day_in),
        .i_month_in      (i_month_in),
        .i_year_in       (i_year_in),
        .o_valid         (o_valid),
        .o_epoch_seconds (o_epoch_seconds),
        .o_second_out    (o_second_out),
        .o_minute_out    (o_minute_out),
        .o_hour_out      (o_hour_out),
        .o_day_out       (o_day_out),
        .o_month_out     (o_month_out),
        .o_year_out      (o_year_out),
        .o_year_day      (o_year_day),
        .o_week_day      (o_week_day),
        .o_range_error   (o_range_error)
    );

endmodule
`default_nettype wire
